[rtl/core/sliding_window_avg_min_max_core_defines.svh]
// Assertion macros shared by the sliding-window checker.
`ifndef SLIDING_WINDOW_AVG_MIN_MAX_CORE_DEFINES_SVH
`define SLIDING_WINDOW_AVG_MIN_MAX_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWAMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWAMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swamm_pkg.sv]
// Package with sizes, payload types and sequencer states of the sliding-window core.
package swamm_pkg;

  localparam int unsigned WINDOW      = 50;
  localparam int unsigned PTR_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W       = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W       = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COUNT_OUT_W = 6;
  localparam int unsigned ENTRY_W     = 2 * SAMPLE_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0] co2_sample;
    logic [SAMPLE_W-1:0] pm25_sample;
  } swamm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]    co2_mean;
    logic [SAMPLE_W-1:0]    pm25_mean;
    logic [SAMPLE_W-1:0]    pm25_min;
    logic [SAMPLE_W-1:0]    pm25_max;
    logic [COUNT_OUT_W-1:0] valid_count;
  } swamm_out_t;

  // Request to the shared serial divider.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } swamm_div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DIV_PM,
    ST_OUT
  } swamm_state_e;

endpackage

[rtl/core/swamm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module swamm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/swamm_div.sv]
// Restoring serial divider that produces one quotient bit per cycle.
module swamm_div import swamm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swamm_div_req_t   req_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d  = {quo_q[SUM_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/sliding_window_avg_min_max_core.sv]
// Sliding-window CO2/PM2.5 averager with PM2.5 minimum and maximum tracking.
// Each accepted beat writes one CO2/PM2.5 pair into a ring RAM of WINDOW entries and
// returns one result beat with the truncated means, the PM2.5 minimum and maximum and the
// held count. The time an item takes is set by the single RAM read port, which scans the
// held entries one per cycle, and by the one serial divider, which produces one quotient
// bit per cycle for each of the two means; the CO2 division overlaps the scan. The input
// is ready only between items, but it also takes a new beat while the previous result
// still waits in the output register.
module sliding_window_avg_min_max_core import swamm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  swamm_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output swamm_out_t out_data_o
);

  swamm_state_e state_q, state_d;

  logic [PTR_W-1:0]    wp_q, wp_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    co2_sum_q, co2_sum_d;
  logic [SUM_W-1:0]    pm_sum_q, pm_sum_d;
  logic [CNT_W-1:0]    scan_idx_q, scan_idx_d;
  logic                rd_pend_q, rd_pend_d;
  logic                rd_first_q, rd_first_d;
  logic                co2_done_q, co2_done_d;
  logic                out_valid_q, out_valid_d;

  logic [SAMPLE_W-1:0] co2_in_q, co2_in_d;
  logic [SAMPLE_W-1:0] pm_in_q, pm_in_d;
  logic [SAMPLE_W-1:0] min_q, min_d;
  logic [SAMPLE_W-1:0] max_q, max_d;
  logic [SAMPLE_W-1:0] co2_mean_q, co2_mean_d;
  logic [SAMPLE_W-1:0] pm_mean_q, pm_mean_d;
  swamm_out_t          out_data_q, out_data_d;

  logic                ram_we;
  logic                ram_re;
  logic [PTR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0] old_co2;
  logic [SAMPLE_W-1:0] old_pm;
  logic [SAMPLE_W-1:0] scan_pm;
  logic                full;

  swamm_div_req_t      div_req;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;

  // Sample ring storage: CO2 in the upper half, PM2.5 in the lower half.
  swamm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({co2_in_q, pm_in_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared divider for both means.
  swamm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign full    = (count_q == CNT_W'(WINDOW));
  assign old_co2 = full ? ram_rdata[ENTRY_W-1:SAMPLE_W] : '0;
  assign old_pm  = full ? ram_rdata[SAMPLE_W-1:0] : '0;
  assign scan_pm = ram_rdata[SAMPLE_W-1:0];

  // Sequencer: next state, datapath updates and RAM and divider control.
  always_comb begin
    state_d          = state_q;
    wp_d             = wp_q;
    count_d          = count_q;
    co2_sum_d        = co2_sum_q;
    pm_sum_d         = pm_sum_q;
    scan_idx_d       = scan_idx_q;
    rd_pend_d        = 1'b0;
    rd_first_d       = rd_first_q;
    co2_done_d       = co2_done_q;
    co2_in_d         = co2_in_q;
    pm_in_d          = pm_in_q;
    min_d            = min_q;
    max_d            = max_q;
    co2_mean_d       = co2_mean_q;
    pm_mean_d        = pm_mean_q;
    out_data_d       = out_data_q;
    out_valid_d      = out_valid_q & ~out_ready_i;
    in_ready_o       = 1'b0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = wp_q;
    div_req.start    = 1'b0;
    div_req.dividend = co2_sum_q;
    div_req.divisor  = count_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // Fetch the entry about to be overwritten.
          co2_in_d  = in_data_i.co2_sample;
          pm_in_d   = in_data_i.pm25_sample;
          ram_re    = 1'b1;
          ram_raddr = wp_q;
          state_d   = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        // Drop the overwritten entry once the window is full, then add the new one.
        ram_we     = 1'b1;
        co2_sum_d  = co2_sum_q - {{(SUM_W - SAMPLE_W){1'b0}}, old_co2}
                   + {{(SUM_W - SAMPLE_W){1'b0}}, co2_in_q};
        pm_sum_d   = pm_sum_q - {{(SUM_W - SAMPLE_W){1'b0}}, old_pm}
                   + {{(SUM_W - SAMPLE_W){1'b0}}, pm_in_q};
        count_d    = full ? count_q : count_q + CNT_W'(1);
        wp_d       = (wp_q == PTR_W'(WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
        scan_idx_d = '0;
        co2_done_d = 1'b0;
        state_d    = ST_SCAN;
      end

      ST_SCAN: begin
        // The CO2 division runs alongside the min/max scan.
        if (scan_idx_q == '0) begin
          div_req.start = 1'b1;
        end
        if (div_done) begin
          co2_mean_d = div_quo[SAMPLE_W-1:0];
          co2_done_d = 1'b1;
        end
        // Issue one read per cycle over the held entries.
        if (scan_idx_q < count_q) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_idx_q[PTR_W-1:0];
          scan_idx_d = scan_idx_q + CNT_W'(1);
          rd_pend_d  = 1'b1;
          rd_first_d = (scan_idx_q == '0);
        end
        // Fold in the entry read in the previous cycle.
        if (rd_pend_q) begin
          if (rd_first_q) begin
            min_d = scan_pm;
            max_d = scan_pm;
          end else begin
            if (scan_pm < min_q) begin
              min_d = scan_pm;
            end
            if (scan_pm > max_q) begin
              max_d = scan_pm;
            end
          end
        end
        if ((scan_idx_q == count_q) && !rd_pend_q && (co2_done_q || div_done)) begin
          div_req.start    = 1'b1;
          div_req.dividend = pm_sum_q;
          state_d          = ST_DIV_PM;
        end
      end

      ST_DIV_PM: begin
        if (div_done) begin
          pm_mean_d = div_quo[SAMPLE_W-1:0];
          state_d   = ST_OUT;
        end
      end

      ST_OUT: begin
        // Load the result once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_data_d.co2_mean    = co2_mean_q;
          out_data_d.pm25_mean   = pm_mean_q;
          out_data_d.pm25_min    = min_q;
          out_data_d.pm25_max    = max_q;
          out_data_d.valid_count = COUNT_OUT_W'(count_q);
          out_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and window bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      count_q     <= '0;
      co2_sum_q   <= '0;
      pm_sum_q    <= '0;
      scan_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      rd_first_q  <= 1'b0;
      co2_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      count_q     <= count_d;
      co2_sum_q   <= co2_sum_d;
      pm_sum_q    <= pm_sum_d;
      scan_idx_q  <= scan_idx_d;
      rd_pend_q   <= rd_pend_d;
      rd_first_q  <= rd_first_d;
      co2_done_q  <= co2_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    co2_in_q   <= co2_in_d;
    pm_in_q    <= pm_in_d;
    min_q      <= min_d;
    max_q      <= max_d;
    co2_mean_q <= co2_mean_d;
    pm_mean_q  <= pm_mean_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/core/swamm_chk.sv]
// Port-level checker for the sliding-window core and its bind statement.
`include "sliding_window_avg_min_max_core_defines.svh"

module swamm_chk import swamm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input swamm_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input swamm_out_t out_data_o
);

  // A stalled result beat stays offered.
  `SWAMM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped while stalled")

  // A stalled result beat keeps its payload.
  `SWAMM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result payload changed while stalled")

  // The core is busy for the cycle after it takes a beat.
  `SWAMM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "input ready right after an accepted beat")

  // The PM2.5 mean lies between the window minimum and maximum.
  `SWAMM_ASSERT_SAME(a_mean_in_range, out_valid_o, (out_data_o.pm25_min <= out_data_o.pm25_mean) && (out_data_o.pm25_mean <= out_data_o.pm25_max), "PM2.5 mean outside min and max")

endmodule

bind sliding_window_avg_min_max_core swamm_chk u_swamm_chk (.*);
